// File: rtl/dws_pkg.sv
package dws_pkg;

  // Sizing of the ring store
  localparam int DEPTH     = 32;
  localparam int ITEM_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;

  // Fixed field widths at the ports
  localparam int REQ_W = 4;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int TOT_W = 6;

  typedef logic [ITEM_BITS-1:0] item_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [VAL_W-1:0]     val_t;
  typedef logic [ST_W-1:0]      st_t;
  typedef logic [TOT_W-1:0]     tot_t;

  // Request codes
  localparam req_t REQ_PUSH_FRONT = 4'd0;
  localparam req_t REQ_PUSH_BACK  = 4'd1;
  localparam req_t REQ_POP_FRONT  = 4'd2;
  localparam req_t REQ_POP_BACK   = 4'd3;
  localparam req_t REQ_PEEK_FRONT = 4'd4;
  localparam req_t REQ_PEEK_BACK  = 4'd5;
  localparam req_t REQ_FIND       = 4'd6;
  localparam req_t REQ_REMOVE     = 4'd7;
  localparam req_t REQ_DUMP       = 4'd8;

  // Status codes
  localparam st_t ST_OK       = 2'd0;
  localparam st_t ST_EMPTY    = 2'd1;
  localparam st_t ST_FULL     = 2'd2;
  localparam st_t ST_NO_MATCH = 2'd3;

  // Port word to stored item, keeping the low ITEM_BITS bits.
  function automatic item_t to_item(val_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[ITEM_BITS-1:0];
  endfunction

  // Stored item to port word, keeping the low 32 bits.
  function automatic val_t from_item(item_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[VAL_W-1:0];
  endfunction

  // Entry count to the entry_total field.
  function automatic tot_t to_total(cnt_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[TOT_W-1:0];
  endfunction

endpackage

// File: rtl/dws_req_if.sv
interface dws_req_if;
  import dws_pkg::*;

  logic  valid;
  logic  ready;
  req_t  req_type;
  val_t  item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);

endinterface

// File: rtl/dws_rsp_if.sv
interface dws_rsp_if;
  import dws_pkg::*;

  logic  valid;
  logic  ready;
  val_t  result_value;
  st_t   status;
  tot_t  entry_total;
  logic  last_result;

  modport source (output valid, output result_value, output status, output entry_total,
                  output last_result, input ready);
  modport sink   (input valid, input result_value, input status, input entry_total,
                  input last_result, output ready);

endinterface

// File: rtl/dws_cmp.sv
module dws_cmp (
  input  dws_pkg::item_t entry_i,
  input  dws_pkg::item_t key_i,
  input  dws_pkg::val_t  mask_i,
  output logic           match_o
);
  import dws_pkg::*;

  // Masked equality over the low 32 bits of entry and key.
  assign match_o = ((from_item(entry_i) ^ from_item(key_i)) & mask_i) == '0;

endmodule

// File: rtl/deque_with_search.sv
// Bounded double-ended queue with search, held as a ring of DEPTH item words.
// Requests arrive on req_i (req_type, item_value) and every result leaves on
// rsp_o (result_value, status, entry_total, last_result); a transfer happens
// when valid and ready are both high. compare_mask is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle, as the block does not enforce it.
// One request is worked at a time; req_i.ready is high only while the
// sequencer is idle, and a result already waiting in the output register does
// not hold off the next request. Push, unknown requests and any request on an
// empty queue are answered from the exec state; pop and peek go on through the
// address, wait and data states, since the single memory read port is
// registered; find, remove and dump run those states once per entry walked,
// each walk step being one read and one pass through the shared compare unit.
// A dump gives one result per entry, with last_result on the final one. The
// next request can be taken in the cycle after the final result is issued.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits before it issues the next result.
// Reset empties the queue (front and count to zero) and sets compare_mask to
// all ones; the entry memory itself is not cleared and needs no clearing pass.
module deque_with_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  dws_pkg::val_t cfg_wdata_i,
  dws_req_if.sink       req_i,
  dws_rsp_if.source     rsp_o
);
  import dws_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  // Ring position of the entry at a given offset from the front.
  function automatic idx_t slot_of(idx_t f, cnt_t off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(f) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [2:0] state_q, state_d;
  req_t       req_q;
  item_t      key_q;
  idx_t       front_q, front_d;
  cnt_t       count_q, count_d;
  cnt_t       idx_q, idx_d;
  cnt_t       keep_q, keep_d;
  val_t       mask_q;
  idx_t       raddr_q, raddr_d;
  item_t      rdata_q;
  item_t      entry_mem [DEPTH];

  logic       mem_we;
  idx_t       mem_waddr;
  item_t      mem_wdata;

  logic       emit_en;
  val_t       emit_val;
  st_t        emit_st;
  cnt_t       emit_cnt;
  logic       emit_last;

  logic       out_valid_q;
  val_t       out_val_q;
  st_t        out_st_q;
  tot_t       out_tot_q;
  logic       out_last_q;

  logic       out_free;
  logic       req_xfer;
  logic       match;
  logic       last_ent;
  cnt_t       keep_n;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign last_ent    = (idx_q + cnt_t'(1)) == count_q;
  assign keep_n      = keep_q + cnt_t'(!match);

  // Shared compare unit, used once per walk step.
  dws_cmp u_cmp (
    .entry_i (rdata_q),
    .key_i   (key_q),
    .mask_i  (mask_q),
    .match_o (match)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    keep_d    = keep_q;
    raddr_d   = raddr_q;
    mem_we    = 1'b0;
    mem_waddr = slot_of(front_q, count_q);
    mem_wdata = key_q;
    emit_en   = 1'b0;
    emit_val  = '0;
    emit_st   = ST_OK;
    emit_cnt  = count_q;
    emit_last = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_q) inside
          REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (out_free) begin
              emit_en = 1'b1;
              state_d = S_IDLE;
              if (count_q == cnt_t'(DEPTH)) begin
                emit_st = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                count_d  = count_q + cnt_t'(1);
                emit_cnt = count_q + cnt_t'(1);
                if (req_q == REQ_PUSH_FRONT) begin
                  front_d   = (front_q == '0) ? idx_t'(DEPTH - 1) : front_q - idx_t'(1);
                  mem_waddr = front_d;
                end
              end
            end
          end
          REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
            if (count_q == '0) begin
              if (out_free) begin
                emit_en = 1'b1;
                emit_st = ST_EMPTY;
                state_d = S_IDLE;
              end
            end else begin
              idx_d   = (req_q == REQ_POP_FRONT || req_q == REQ_PEEK_FRONT) ?
                        '0 : count_q - cnt_t'(1);
              state_d = S_ADDR;
            end
          end
          REQ_FIND, REQ_REMOVE, REQ_DUMP: begin
            if (count_q == '0) begin
              if (out_free) begin
                emit_en = 1'b1;
                emit_st = (req_q == REQ_FIND) ? ST_NO_MATCH :
                          (req_q == REQ_DUMP) ? ST_EMPTY : ST_OK;
                state_d = S_IDLE;
              end
            end else begin
              idx_d   = '0;
              keep_d  = '0;
              state_d = S_ADDR;
            end
          end
          default: begin
            if (out_free) begin
              emit_en = 1'b1;
              state_d = S_IDLE;
            end
          end
        endcase
      end

      S_ADDR: begin
        raddr_d = slot_of(front_q, idx_q);
        state_d = S_WAIT;
      end

      S_WAIT: begin
        state_d = S_DATA;
      end

      S_DATA: begin
        if (out_free) begin
          unique case (req_q) inside
            REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
              emit_en  = 1'b1;
              emit_val = from_item(rdata_q);
              state_d  = S_IDLE;
              if (req_q == REQ_POP_FRONT || req_q == REQ_POP_BACK) begin
                count_d  = count_q - cnt_t'(1);
                emit_cnt = count_q - cnt_t'(1);
              end
              if (req_q == REQ_POP_FRONT) begin
                front_d = slot_of(front_q, cnt_t'(1));
              end
            end
            REQ_FIND: begin
              if (match) begin
                emit_en  = 1'b1;
                emit_val = from_item(rdata_q);
                state_d  = S_IDLE;
              end else if (last_ent) begin
                emit_en = 1'b1;
                emit_st = ST_NO_MATCH;
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q + cnt_t'(1);
                state_d = S_ADDR;
              end
            end
            REQ_REMOVE: begin
              // Survivors move down to the next kept position.
              if (!match) begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(front_q, keep_q);
                mem_wdata = rdata_q;
              end
              keep_d = keep_n;
              if (last_ent) begin
                count_d  = keep_n;
                emit_en  = 1'b1;
                emit_val = 32'(count_q - keep_n);
                emit_cnt = keep_n;
                state_d  = S_IDLE;
              end else begin
                idx_d   = idx_q + cnt_t'(1);
                state_d = S_ADDR;
              end
            end
            REQ_DUMP: begin
              emit_en   = 1'b1;
              emit_val  = from_item(rdata_q);
              emit_last = last_ent;
              if (last_ent) begin
                state_d = S_IDLE;
              end else begin
                idx_d   = idx_q + cnt_t'(1);
                state_d = S_ADDR;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      keep_q      <= '0;
      mask_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      keep_q  <= keep_d;
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, read address and result payload
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_q <= req_i.req_type;
      key_q <= to_item(req_i.item_value);
    end
    raddr_q <= raddr_d;
    if (emit_en) begin
      out_val_q  <= emit_val;
      out_st_q   <= emit_st;
      out_tot_q  <= to_total(emit_cnt);
      out_last_q <= emit_last;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entry_mem[raddr_q];
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_val_q;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.entry_total  = out_tot_q;
  assign rsp_o.last_result  = out_last_q;

  // The queue never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  // The front pointer stays inside the ring.
  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(front_q) < SUM_W'(DEPTH))
    else $error("front pointer outside ring");

  // A walk step only reads a held entry.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> (idx_q < count_q))
    else $error("walk beyond held entries");

  // Compaction never writes ahead of the read position.
  a_keep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA && req_q == REQ_REMOVE) |-> (keep_q <= idx_q))
    else $error("kept position ahead of read position");

  // A result is only issued when the output register is free.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_en |-> out_free)
    else $error("result issued over a waiting result");

endmodule

// File: tb/deque_with_search_test.sv
`timescale 1ns / 1ps

module deque_with_search_test;
  import dws_pkg::*;

  // One result as it leaves the block.
  typedef struct packed {
    val_t value;
    st_t  status;
    tot_t total;
    logic last;
  } deque_result_t;

  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE_TICKS = 120;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  val_t cfg_wdata_i;

  dws_req_if req_bus ();
  dws_rsp_if rsp_bus ();

  deque_with_search uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  // Our own copy of the ring, its front position, fill level and mask.
  item_t       ring [DEPTH];
  int unsigned head;
  int unsigned held;
  val_t        mask_model;

  deque_result_t awaited_results [$];
  val_t          key_pool [8];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned full_flags;
  int unsigned empty_flags;
  int unsigned miss_flags;
  int unsigned removed_total;
  int unsigned longest_dump;
  int unsigned mask_writes;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Queue one awaited result, tagged with the fill level after the request.
  function automatic void note_result(val_t v, st_t s, logic fin);
    deque_result_t r;
    r.value  = v;
    r.status = s;
    r.total  = tot_t'(held);
    r.last   = fin;
    if (s == ST_FULL) full_flags++;
    if (s == ST_EMPTY) empty_flags++;
    if (s == ST_NO_MATCH) miss_flags++;
    awaited_results.push_back(r);
  endfunction

  function automatic logic keys_agree(item_t entry, item_t key);
    return ((val_t'(entry) ^ val_t'(key)) & mask_model) == '0;
  endfunction

  // Update the ring for one accepted request and work out its results.
  function automatic void predict_results(req_t kind, val_t word);
    item_t       key;
    item_t       entry;
    int unsigned i;
    int unsigned keep;
    logic        found;
    key = item_t'(word);
    requests_sent++;
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (held >= DEPTH) begin
          note_result('0, ST_FULL, 1'b1);
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = key;
          end else begin
            ring[(head + held) % DEPTH] = key;
          end
          held++;
          note_result('0, ST_OK, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
        if (held == 0) begin
          note_result('0, ST_EMPTY, 1'b1);
        end else if (kind == REQ_POP_FRONT || kind == REQ_PEEK_FRONT) begin
          entry = ring[head];
          if (kind == REQ_POP_FRONT) begin
            head = (head + 1) % DEPTH;
            held--;
          end
          note_result(val_t'(entry), ST_OK, 1'b1);
        end else begin
          entry = ring[(head + held - 1) % DEPTH];
          if (kind == REQ_POP_BACK) held--;
          note_result(val_t'(entry), ST_OK, 1'b1);
        end
      end
      REQ_FIND: begin
        found = 1'b0;
        for (i = 0; i < held && !found; i++) begin
          entry = ring[(head + i) % DEPTH];
          if (keys_agree(entry, key)) begin
            found = 1'b1;
            note_result(val_t'(entry), ST_OK, 1'b1);
          end
        end
        if (!found) note_result('0, ST_NO_MATCH, 1'b1);
      end
      REQ_REMOVE: begin
        // Survivors slide towards the front, keeping their order.
        keep = 0;
        for (i = 0; i < held; i++) begin
          entry = ring[(head + i) % DEPTH];
          if (!keys_agree(entry, key)) begin
            ring[(head + keep) % DEPTH] = entry;
            keep++;
          end
        end
        removed_total += held - keep;
        i = held - keep;
        held = keep;
        note_result(val_t'(i), ST_OK, 1'b1);
      end
      REQ_DUMP: begin
        if (held == 0) begin
          note_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (held > longest_dump) longest_dump = held;
          for (i = 0; i < held; i++)
            note_result(val_t'(ring[(head + i) % DEPTH]), ST_OK, i + 1 == held);
        end
      end
      default: begin
        note_result('0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // Offer one request, idling first at random, and predict it on transfer.
  task automatic send_request(req_t kind, val_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.item_value <= word;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    predict_results(kind, word);
  endtask

  // Write the mask once every awaited result is in and the block is idle.
  task automatic set_compare_mask(val_t m);
    req_bus.valid <= 1'b0;
    while (awaited_results.size() != 0 || !req_bus.ready) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    mask_model = m;
    mask_writes++;
  endtask

  // Key words: mostly drawn from a small pool so that searches hit, with
  // unmasked bits scrambled now and then.
  function automatic val_t pick_word();
    val_t w;
    if ($urandom_range(3) == 0) return $urandom();
    w = key_pool[$urandom_range(7)];
    if ($urandom_range(1) == 1) w = w ^ ($urandom() & ~mask_model);
    return w;
  endfunction

  // Results are checked on each transfer; ready is redrawn every cycle.
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none awaited: value %h status %0d total %0d last %0b",
                 $time, rsp_bus.result_value, rsp_bus.status, rsp_bus.entry_total,
                 rsp_bus.last_result);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (rsp_bus.result_value !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value,
                   rsp_bus.result_value);
          error_count++;
        end
        if (rsp_bus.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_bus.status);
          error_count++;
        end
        if (rsp_bus.entry_total !== want.total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time, want.total,
                   rsp_bus.entry_total);
          error_count++;
        end
        if (rsp_bus.last_result !== want.last) begin
          $display("%0t: last_result expected %0b actual %0b", $time, want.last,
                   rsp_bus.last_result);
          error_count++;
        end
      end
    end
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: too long without any transfer means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("deque_with_search verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Every pop, peek, find, remove and dump on an empty queue, and codes with no meaning.
  task automatic test_empty_queue();
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_POP_BACK, '1);
    send_request(REQ_PEEK_FRONT, '0);
    send_request(REQ_PEEK_BACK, '1);
    send_request(REQ_FIND, '0);
    send_request(REQ_REMOVE, '0);
    send_request(REQ_DUMP, '0);
    send_request(req_t'(int'(REQ_DUMP) + 1), 32'h5A5A_5A5A);
    send_request(req_t'(2**REQ_W - 1), '1);
  endtask

  // Pushes, peeks and pops at both ends with extreme item words.
  task automatic test_end_operations();
    send_request(REQ_PUSH_BACK, '0);
    send_request(REQ_PUSH_FRONT, '1);
    send_request(REQ_PUSH_BACK, 32'h8000_0001);
    send_request(REQ_PEEK_FRONT, '0);
    send_request(REQ_PEEK_BACK, '0);
    send_request(REQ_POP_BACK, '0);
    send_request(REQ_POP_FRONT, '0);
    send_request(REQ_DUMP, '0);
  endtask

  // Find and remove under a full mask, a half mask and an empty mask.
  task automatic test_search_under_mask();
    send_request(REQ_PUSH_BACK, 32'h1234_5678);
    send_request(REQ_PUSH_BACK, 32'h1234_0000);
    send_request(REQ_FIND, 32'h0000_5678);
    set_compare_mask(32'h0000_FFFF);
    send_request(REQ_FIND, 32'h0000_5678);
    send_request(REQ_REMOVE, '0);
    send_request(REQ_DUMP, '0);
    set_compare_mask('0);
    send_request(REQ_REMOVE, '1);
    set_compare_mask('1);
  endtask

  // Random mixes under four idling patterns, with runs to a full queue.
  task automatic test_random_phases();
    int unsigned phase;
    int unsigned n;
    int unsigned roll;
    req_t        kind;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      for (n = 0; n < 8; n++) key_pool[n] = $urandom();
      key_pool[0] = '0;
      key_pool[1] = '1;
      case (phase)
        0: set_compare_mask('1);
        1: set_compare_mask($urandom());
        2: set_compare_mask($urandom() | 32'hFFFF_0000);
        default: set_compare_mask($urandom() & $urandom());
      endcase
      for (n = 0; n < 38; n++) begin
        // Half way through two phases: fill up, overflow, then dump it all.
        if ((phase == 1 || phase == 2) && n == 19) begin
          while (held < DEPTH)
            send_request($urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_word());
          send_request(REQ_PUSH_FRONT, $urandom());
          send_request(REQ_PUSH_BACK, $urandom());
          send_request(REQ_DUMP, '0);
        end
        roll = $urandom_range(99);
        if (roll < 20) kind = REQ_PUSH_FRONT;
        else if (roll < 40) kind = REQ_PUSH_BACK;
        else if (roll < 50) kind = REQ_POP_FRONT;
        else if (roll < 60) kind = REQ_POP_BACK;
        else if (roll < 65) kind = REQ_PEEK_FRONT;
        else if (roll < 70) kind = REQ_PEEK_BACK;
        else if (roll < 80) kind = REQ_FIND;
        else if (roll < 88) kind = REQ_REMOVE;
        else if (roll < 96) kind = REQ_DUMP;
        else kind = req_t'($urandom_range(2**REQ_W - 1, int'(REQ_DUMP) + 1));
        send_request(kind, pick_word());
      end
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = '0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_PUSH_FRONT;
    req_bus.item_value  = '0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    error_count         = 0;
    requests_sent       = 0;
    results_checked     = 0;
    full_flags          = 0;
    empty_flags         = 0;
    miss_flags          = 0;
    removed_total       = 0;
    longest_dump        = 0;
    mask_writes         = 0;
    head                = 0;
    held                = 0;
    mask_model          = '1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_end_operations();
    test_search_under_mask();
    test_random_phases();

    // Drain the remaining results, then give any stray transfer time to show.
    req_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);

    $display("Covered %0d requests and %0d results over %0d mask settings; longest dump %0d.",
             requests_sent, results_checked, mask_writes, longest_dump);
    $display("Flags seen: %0d full, %0d empty, %0d no match; %0d entries removed.",
             full_flags, empty_flags, miss_flags, removed_total);
    if (error_count == 0) begin
      $display("deque_with_search verification clean");
    end else begin
      $display("deque_with_search verification failed");
    end
    $finish;
  end

endmodule

// File: deque_with_search.f
rtl/dws_pkg.sv
rtl/dws_req_if.sv
rtl/dws_rsp_if.sv
rtl/dws_cmp.sv
rtl/deque_with_search.sv
tb/deque_with_search_test.sv
